/* sv/hgsd_pkg.sv */
// Package for the greedy hidden Markov state decoder: table sizes, field widths,
// operation and configuration register codes, and the sequencer state type.
// Depends on nothing; used by hmm_greedy_state_decoder.
`default_nettype none

package hgsd_pkg;

  // Table geometry, fixed by the field widths of the item ports.
  localparam int MAX_STATES         = 16;
  localparam int MAX_SYMBOLS        = 26;
  localparam int PROB_FRACTION_BITS = 16;

  localparam int STATE_W  = $clog2(MAX_STATES);
  localparam int COUNT_W  = 5;
  localparam int SYMBOL_W = 5;
  localparam int PROB_W   = PROB_FRACTION_BITS + 1;
  localparam int SCORE_W  = 2 * PROB_W;

  localparam int TRANS_DEPTH = MAX_STATES * MAX_STATES;
  localparam int EMIS_DEPTH  = MAX_STATES * MAX_SYMBOLS;
  localparam int TRANS_AW    = $clog2(TRANS_DEPTH);
  localparam int EMIS_AW     = $clog2(EMIS_DEPTH);

  localparam logic [PROB_W-1:0] PROB_ONE = PROB_W'(1) << PROB_FRACTION_BITS;

  typedef enum logic [1:0] {
    OP_LOAD_TRANS = 2'd0,
    OP_LOAD_EMIS  = 2'd1,
    OP_DECODE     = 2'd2,
    OP_UNUSED     = 2'd3
  } op_t;

  typedef enum logic [1:0] {
    CFG_STATE_COUNT       = 2'd0,
    CFG_SYMBOL_COUNT      = 2'd1,
    CFG_USE_INITIAL_STATE = 2'd2,
    CFG_INITIAL_STATE     = 2'd3
  } cfg_index_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_DRAIN,
    ST_FINISH
  } seq_state_t;

endpackage

`default_nettype wire

/* sv/hmm_greedy_state_decoder.sv */
// Greedy hidden Markov state decoder: top level with table memories, the scan
// sequencer and one shared multiply-compare unit.
// Depends on hgsd_pkg.
//
// Usage. The input channel (in_valid / in_ready) carries one item per handshake.
// An item with op set to load transition or load emission writes one table
// entry (values above 1.0 saturate to 1.0, out-of-range places are ignored)
// and is taken with no result. A decode item produces exactly
// one result item on the output channel (out_valid / out_ready).
// A decode item scans the active states one per cycle through a single
// 17 x 17 multiplier and one 34-bit compare; the scan is followed by the read,
// multiply and compare stages draining in ST_DRAIN, then ST_FINISH loads the
// result register, and the input is ready again only once the sequencer is
// back in idle, so no new item is taken while a decode is in progress.
// A bad symbol or a forced initial state skips the scan: the item goes from
// idle straight to ST_FINISH, which loads its result register.
// The result sits in an output register, so loads and the next decode may be
// accepted while it waits; a decode that finishes while the previous result has
// not been taken holds in its final state until the output register frees up.
// Configuration is written through cfg_we / cfg_index / cfg_data with no wait;
// the user must write it only while the block is idle; the block does not enforce it.
// Reset (rst, synchronous) returns the sequencer to idle, drops out_valid,
// clears the previous state and restores the register defaults. The table
// memories are not cleared; entries must be loaded before they are used.
`default_nettype none

module hmm_greedy_state_decoder (
  input  wire logic                          clk,
  input  wire logic                          rst,
  // Input channel
  input  wire logic                          in_valid,
  output logic                               in_ready,
  input  wire logic [1:0]                    op,
  input  wire logic [3:0]                    row_state,
  input  wire logic [4:0]                    column_index,
  input  wire logic [16:0]                   probability,
  input  wire logic [4:0]                    symbol,
  input  wire logic                          first_of_sequence,
  // Output channel
  output logic                               out_valid,
  input  wire logic                          out_ready,
  output logic [3:0]                         decoded_state,
  output logic                               symbol_error,
  // Configuration write port
  input  wire logic                          cfg_we,
  input  wire logic [1:0]                    cfg_index,
  input  wire logic [4:0]                    cfg_data
);

  localparam int STATE_W = hgsd_pkg::STATE_W;
  localparam int COUNT_W = hgsd_pkg::COUNT_W;
  localparam int PROB_W  = hgsd_pkg::PROB_W;
  localparam int SCORE_W = hgsd_pkg::SCORE_W;
  localparam int TAW     = hgsd_pkg::TRANS_AW;
  localparam int EAW     = hgsd_pkg::EMIS_AW;

  // Configuration registers
  logic [COUNT_W-1:0] state_count;
  logic [COUNT_W-1:0] symbol_count;
  logic               use_initial_state;
  logic [STATE_W-1:0] initial_state;

  // Sequencer
  hgsd_pkg::seq_state_t state, state_next;

  // Decode context
  logic [STATE_W-1:0] previous_state;
  logic [STATE_W-1:0] scan_prev;
  logic               first_mode;
  logic [STATE_W-1:0] scan_index;
  logic [EAW-1:0]     emis_raddr;
  logic [STATE_W-1:0] chosen;
  logic               result_error;
  logic [SCORE_W-1:0] best;

  // Read, multiply and compare stages
  logic               rd_valid, rd_last;
  logic [STATE_W-1:0] rd_index;
  logic               mul_valid, mul_last;
  logic [STATE_W-1:0] mul_index;
  logic [SCORE_W-1:0] product;

  // Memories
  logic [PROB_W-1:0] trans_mem [0:hgsd_pkg::TRANS_DEPTH-1];
  logic [PROB_W-1:0] emis_mem  [0:hgsd_pkg::EMIS_DEPTH-1];
  logic [PROB_W-1:0] trans_q;
  logic [PROB_W-1:0] emis_q;

  // Derived values
  logic [STATE_W-1:0] last_state;
  logic [COUNT_W-1:0] count_minus_one;
  logic [COUNT_W-1:0] symbol_limit;
  logic               accept;
  logic               accept_decode;
  logic               bad_symbol;
  logic               scan_last;
  logic               out_free;
  logic [PROB_W-1:0]  load_value;
  logic               trans_we;
  logic               emis_we;
  logic [TAW-1:0]     trans_waddr;
  logic [EAW-1:0]     emis_waddr;
  logic [TAW-1:0]     trans_raddr;
  logic [PROB_W-1:0]  mul_a;
  hgsd_pkg::op_t      item_op;

  assign item_op = hgsd_pkg::op_t'(op);

  // Active state count clamped to 1..MAX_STATES, kept as its top index.
  assign count_minus_one = state_count - COUNT_W'(1);
  always_comb begin
    if (state_count == '0) begin
      last_state = '0;
    end else if (state_count > COUNT_W'(hgsd_pkg::MAX_STATES)) begin
      last_state = STATE_W'(hgsd_pkg::MAX_STATES - 1);
    end else begin
      last_state = count_minus_one[STATE_W-1:0];
    end
  end

  assign symbol_limit = (symbol_count > COUNT_W'(hgsd_pkg::MAX_SYMBOLS)) ?
                        COUNT_W'(hgsd_pkg::MAX_SYMBOLS) : symbol_count;
  assign bad_symbol   = (symbol >= symbol_limit);

  assign in_ready      = (state == hgsd_pkg::ST_IDLE);
  assign accept        = in_valid && in_ready;
  assign accept_decode = accept && (item_op == hgsd_pkg::OP_DECODE);
  assign scan_last     = (scan_index == last_state);
  assign out_free      = !out_valid || out_ready;

  // Table loads: saturate to 1.0, drop places outside the tables.
  assign load_value  = (probability > hgsd_pkg::PROB_ONE) ? hgsd_pkg::PROB_ONE : probability;
  assign trans_we    = accept && (item_op == hgsd_pkg::OP_LOAD_TRANS) &&
                       (column_index < COUNT_W'(hgsd_pkg::MAX_STATES));
  assign emis_we     = accept && (item_op == hgsd_pkg::OP_LOAD_EMIS) &&
                       (column_index < COUNT_W'(hgsd_pkg::MAX_SYMBOLS));
  assign trans_waddr = {row_state, column_index[STATE_W-1:0]};
  assign emis_waddr  = EAW'(row_state) * EAW'(hgsd_pkg::MAX_SYMBOLS) + EAW'(column_index);
  assign trans_raddr = {scan_prev, scan_index};

  always_ff @(posedge clk) begin
    if (trans_we) begin
      trans_mem[trans_waddr] <= load_value;
    end
    trans_q <= trans_mem[trans_raddr];
  end

  always_ff @(posedge clk) begin
    if (emis_we) begin
      emis_mem[emis_waddr] <= load_value;
    end
    emis_q <= emis_mem[emis_raddr];
  end

  // Configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state_count       <= COUNT_W'(16);
      symbol_count      <= COUNT_W'(26);
      use_initial_state <= 1'b0;
      initial_state     <= '0;
    end else if (cfg_we) begin
      unique case (hgsd_pkg::cfg_index_t'(cfg_index))
        hgsd_pkg::CFG_STATE_COUNT:       state_count       <= cfg_data;
        hgsd_pkg::CFG_SYMBOL_COUNT:      symbol_count      <= cfg_data;
        hgsd_pkg::CFG_USE_INITIAL_STATE: use_initial_state <= cfg_data[0];
        hgsd_pkg::CFG_INITIAL_STATE:     initial_state     <= cfg_data[STATE_W-1:0];
        default: ;
      endcase
    end
  end

  // Sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= hgsd_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      hgsd_pkg::ST_IDLE: begin
        if (accept_decode) begin
          if (bad_symbol || (first_of_sequence && use_initial_state)) begin
            state_next = hgsd_pkg::ST_FINISH;
          end else begin
            state_next = hgsd_pkg::ST_SCAN;
          end
        end
      end
      hgsd_pkg::ST_SCAN: begin
        if (scan_last) begin
          state_next = hgsd_pkg::ST_DRAIN;
        end
      end
      hgsd_pkg::ST_DRAIN: begin
        if (mul_valid && mul_last) begin
          state_next = hgsd_pkg::ST_FINISH;
        end
      end
      hgsd_pkg::ST_FINISH: begin
        if (out_free) begin
          state_next = hgsd_pkg::ST_IDLE;
        end
      end
      default: state_next = hgsd_pkg::ST_IDLE;
    endcase
  end

  // Issue side of the scan: one state index and its two table addresses per cycle.
  always_ff @(posedge clk) begin
    if (accept_decode) begin
      scan_index <= '0;
      emis_raddr <= EAW'(symbol);
      first_mode <= first_of_sequence;
      scan_prev  <= (previous_state > last_state) ? last_state : previous_state;
    end else if (state == hgsd_pkg::ST_SCAN && !scan_last) begin
      scan_index <= scan_index + STATE_W'(1);
      emis_raddr <= emis_raddr + EAW'(hgsd_pkg::MAX_SYMBOLS);
    end
  end

  // Read-data stage tags travel alongside the registered memory outputs.
  always_ff @(posedge clk) begin
    if (rst) begin
      rd_valid  <= 1'b0;
      mul_valid <= 1'b0;
    end else begin
      rd_valid  <= (state == hgsd_pkg::ST_SCAN);
      mul_valid <= rd_valid;
    end
  end

  // For a first symbol the emission alone is the score; scaling it by 1.0
  // keeps its order and its ties, so the same unit serves both cases.
  assign mul_a = first_mode ? hgsd_pkg::PROB_ONE : trans_q;

  always_ff @(posedge clk) begin
    rd_last   <= scan_last;
    rd_index  <= scan_index;
    mul_last  <= rd_last;
    mul_index <= rd_index;
    product   <= SCORE_W'(mul_a) * SCORE_W'(emis_q);
  end

  // Compare stage and result. A later state wins on an equal score, so ties
  // and an all-zero scan end on the highest index.
  always_ff @(posedge clk) begin
    if (accept_decode) begin
      best         <= '0;
      chosen       <= '0;
      result_error <= bad_symbol;
      if (!bad_symbol && first_of_sequence && use_initial_state) begin
        chosen <= (initial_state > last_state) ? last_state : initial_state;
      end
    end else if (mul_valid && product >= best) begin
      best   <= product;
      chosen <= mul_index;
    end
  end

  // Output register and the state carried to the next symbol.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid      <= 1'b0;
      previous_state <= '0;
    end else if (state == hgsd_pkg::ST_FINISH && out_free) begin
      out_valid     <= 1'b1;
      decoded_state <= chosen;
      symbol_error  <= result_error;
      if (!result_error) begin
        previous_state <= chosen;
      end
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

endmodule

`default_nettype wire
